/* design/abtjm_pkg.sv */
// Shared types, constants and codes for the audio block timing jitter monitor.
package abtjm_pkg;

   localparam int NUM_BUCKETS_DEF = 32;
   localparam int HISTO_W         = 14;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 63;

   localparam logic [HISTO_W-1:0] PRUNE_LIMIT = 14'd10000;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TICKS_PER_SAMPLE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_TICKS      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESTART_INTERVAL = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLICK_ON_DROPOUT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLICK_ON_WARNING = 3'd4;

   localparam logic [39:0] TPS_RESET     = 40'd1481763;
   localparam logic [31:0] BLOCK_RESET   = 32'd11609977;
   localparam logic [62:0] RESTART_RESET = 63'd3600000000000;

   // click codes
   localparam logic [1:0] CLICK_NONE = 2'd0;
   localparam logic [1:0] CLICK_POS  = 2'd1;
   localparam logic [1:0] CLICK_NEG  = 2'd2;

   // histogram write source
   localparam logic [1:0] WSEL_CLEAR = 2'd0;
   localparam logic [1:0] WSEL_INC   = 2'd1;
   localparam logic [1:0] WSEL_PRUNE = 2'd2;

   // histogram read address source
   localparam logic [1:0] RSEL_BUCKET = 2'd0;
   localparam logic [1:0] RSEL_SWEEP  = 2'd1;
   localparam logic [1:0] RSEL_USER   = 2'd2;

   typedef struct packed {
      logic [62:0] now_ticks;
      logic [15:0] block_samples;
      logic [4:0]  histo_read_index;
   } req_type;

   typedef struct packed {
      logic        dropout;
      logic        warning;
      logic [1:0]  click;
      logic [4:0]  bucket;
      logic [62:0] spread_ticks;
      logic [62:0] delta_ticks;
      logic        restarted;
      logic [31:0] dropouts_so_far;
      logic [31:0] warnings_so_far;
      logic [13:0] histo_read_value;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       check;
      logic       mul_a;
      logic       mul_b;
      logic       sum;
      logic       upd;
      logic       meas;
      logic       scale;
      logic       div_step;
      logic       finish;
      logic       idx_clr;
      logic       idx_inc;
      logic       ram_we;
      logic [1:0] wsel;
      logic [1:0] rsel;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic idx_end;
      logic div_last;
      logic prune_need;
      logic out_free;
   } sts_type;

endpackage

/* design/audio_block_timing_jitter_monitor.sv */
// Top level of the audio block timing jitter monitor.
//
// One req transfer is one audio block arrival (timestamp, sample count and a
// histogram bucket to read back). Each produces exactly one rsp transfer with
// dropout/warning flags, click request, bucket, spread, delta and running totals.
// The user must write registers through the csr port only while idle (not enforced).
//
// The sequencer steps through an age check, two 40x20 multiplies for the
// sample offset, the tracking update, one divider step per bucket index
// bit, a histogram read-modify-write and the read-back, and returns to
// idle before it takes the next block. When a bucket passes 10000 a prune
// sweep runs over every bucket. One block is in work at a time; req_ready
// is high while the sequencer waits.
//
// After reset the histogram is zeroed by a clearing pass over every bucket,
// during which req_ready stays low; csr writes are taken throughout.
// The result sits in an output register: a new block is taken while it
// waits, and if rsp_ready stays low the next result holds in the sequencer.
module audio_block_timing_jitter_monitor
   import abtjm_pkg::*;
#(
   parameter int NUM_BUCKETS = NUM_BUCKETS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int BW = $clog2(NUM_BUCKETS);

   cmd_type            cmd;
   sts_type            sts;
   logic               ram_we;
   logic [BW-1:0]      ram_waddr;
   logic [BW-1:0]      ram_raddr;
   logic [HISTO_W-1:0] ram_wdata;
   logic [HISTO_W-1:0] ram_rdata;

   // sequencer
   abtjm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // arithmetic, tracking state and the result register
   abtjm_dp #(
      .NUM_BUCKETS (NUM_BUCKETS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   // delta histogram
   abtjm_ram #(
      .WIDTH (HISTO_W),
      .DEPTH (NUM_BUCKETS)
   ) u_histo (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule

/* design/abtjm_ram.sv */
// Generic single write, single registered read port RAM.
module abtjm_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* design/abtjm_ctrl.sv */
// Sequencer for the jitter monitor: clear pass, per-block steps, prune sweep.
module abtjm_ctrl
   import abtjm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_CHECK = 4'd2;
   localparam logic [3:0] ST_MULA  = 4'd3;
   localparam logic [3:0] ST_MULB  = 4'd4;
   localparam logic [3:0] ST_SUM   = 4'd5;
   localparam logic [3:0] ST_UPD   = 4'd6;
   localparam logic [3:0] ST_MEAS  = 4'd7;
   localparam logic [3:0] ST_SCALE = 4'd8;
   localparam logic [3:0] ST_DIV   = 4'd9;
   localparam logic [3:0] ST_HREAD = 4'd10;
   localparam logic [3:0] ST_HINC  = 4'd11;
   localparam logic [3:0] ST_PRD   = 4'd12;
   localparam logic [3:0] ST_PWR   = 4'd13;
   localparam logic [3:0] ST_RREAD = 4'd14;
   localparam logic [3:0] ST_OUT   = 4'd15;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.wsel  = WSEL_CLEAR;
      cmd.rsel  = RSEL_BUCKET;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.ram_we  = 1'b1;
            cmd.wsel    = WSEL_CLEAR;
            cmd.idx_inc = 1'b1;
            if (sts.idx_end) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = ST_MULA;
         end
         ST_MULA: begin
            cmd.mul_a = 1'b1;
            state_in  = ST_MULB;
         end
         ST_MULB: begin
            cmd.mul_b = 1'b1;
            state_in  = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            cmd.upd  = 1'b1;
            state_in = ST_MEAS;
         end
         ST_MEAS: begin
            cmd.meas = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale   = 1'b1;
            cmd.idx_clr = 1'b1;
            state_in    = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cmd.idx_inc  = 1'b1;
            if (sts.div_last) begin
               state_in = ST_HREAD;
            end
         end
         ST_HREAD: begin
            cmd.rsel = RSEL_BUCKET;
            state_in = ST_HINC;
         end
         ST_HINC: begin
            cmd.ram_we  = 1'b1;
            cmd.wsel    = WSEL_INC;
            cmd.finish  = 1'b1;
            cmd.idx_clr = 1'b1;
            state_in    = sts.prune_need ? ST_PRD : ST_RREAD;
         end
         ST_PRD: begin
            cmd.rsel = RSEL_SWEEP;
            state_in = ST_PWR;
         end
         ST_PWR: begin
            cmd.ram_we  = 1'b1;
            cmd.wsel    = WSEL_PRUNE;
            cmd.idx_inc = 1'b1;
            state_in    = sts.idx_end ? ST_RREAD : ST_PRD;
         end
         ST_RREAD: begin
            cmd.rsel = RSEL_USER;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // keep the read-back address so the count holds while stalled
            cmd.rsel = RSEL_USER;
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !cmd.ram_we)
      else $error("accept while histogram is written");
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_CHECK)
      else $error("accepted block not processed");
   assert property (@(posedge clock) disable iff (reset)
      $rose(req_ready) |-> $past(state_ff) == ST_OUT || $past(state_ff) == ST_CLEAR)
      else $error("ready raised from wrong state");

endmodule

/* design/abtjm_dp.sv */
// Datapath: config registers, start inference, tracking, divider, histogram, result.
module abtjm_dp
   import abtjm_pkg::*;
#(
   parameter int NUM_BUCKETS = NUM_BUCKETS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [CSR_INDEX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata,
   input  req_type                      req_data,
   output rsp_type                      rsp_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  cmd_type                      cmd,
   output sts_type                      sts,
   output logic                         ram_we,
   output logic [$clog2(NUM_BUCKETS)-1:0] ram_waddr,
   output logic [HISTO_W-1:0]           ram_wdata,
   output logic [$clog2(NUM_BUCKETS)-1:0] ram_raddr,
   input  logic [HISTO_W-1:0]           ram_rdata
);

   localparam int BW = $clog2(NUM_BUCKETS);
   localparam int PW = 32 + BW;
   localparam logic [BW-1:0] TOP_BUCKET = BW'(NUM_BUCKETS - 1);
   localparam logic [BW-1:0] HALF       = BW'(NUM_BUCKETS / 2);
   localparam logic [63:0]   SIGN64     = 64'h8000_0000_0000_0000;

   // configuration
   logic [39:0] tps_ff, tps_in;
   logic [31:0] bt_ff, bt_in;
   logic [62:0] rit_ff, rit_in;
   logic        cod_ff, cod_in;
   logic        cow_ff, cow_in;

   always_comb begin
      tps_in = tps_ff;
      bt_in  = bt_ff;
      rit_in = rit_ff;
      cod_in = cod_ff;
      cow_in = cow_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TICKS_PER_SAMPLE: tps_in = csr_wdata[39:0];
            CSR_BLOCK_TICKS:      bt_in  = csr_wdata[31:0];
            CSR_RESTART_INTERVAL: rit_in = csr_wdata;
            CSR_CLICK_ON_DROPOUT: cod_in = csr_wdata[0];
            CSR_CLICK_ON_WARNING: cow_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic [31:0] bt_eff;
   assign bt_eff = (bt_ff == '0) ? 32'd1 : bt_ff;

   // item and tracking state
   logic [62:0]   now_ff, now_in;
   logic [15:0]   nsamp_ff, nsamp_in;
   logic [4:0]    ridx_ff, ridx_in;
   logic [63:0]   earliest_ff, earliest_in;
   logic [63:0]   latest_ff, latest_in;
   logic [39:0]   samples_ff, samples_in;
   logic          restart_ff, restart_in;
   logic [59:0]   a_ff, a_in;
   logic [43:0]   b_ff, b_in;
   logic [63:0]   start_ff, start_in;
   logic [63:0]   spread_ff, spread_in;
   logic [63:0]   delta_ff, delta_in;
   logic          ge_ff, ge_in;
   logic          drop_ff, drop_in;
   logic          warn_ff, warn_in;
   logic [PW-1:0] rem_ff, rem_in;
   logic [PW-1:0] div_ff, div_in;
   logic [BW-1:0] q_ff, q_in;
   logic [BW-1:0] idx_ff, idx_in;
   logic [31:0]   dtot_ff, dtot_in;
   logic [31:0]   wtot_ff, wtot_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [63:0] now64, age, off, r_sum;
   logic [40:0] samp_sum;
   logic        old_enough;
   logic [BW-1:0] bucket;
   logic [HISTO_W-1:0] inc_val;
   logic [HISTO_W+2:0] prune_x7;
   logic [HISTO_W-1:0] prune_val;
   logic        ridx_ok;

   assign now64    = {1'b0, now_ff};
   assign age      = now64 - earliest_ff;
   assign r_sum    = {a_ff, 4'b0} + {20'b0, b_ff};
   assign samp_sum = {1'b0, samples_ff} + {25'b0, nsamp_ff};
   assign bucket   = ge_ff ? TOP_BUCKET : q_ff;
   assign inc_val  = ram_rdata + 14'd1;
   assign prune_x7 = {3'b0, ram_rdata} * 17'd7;
   assign prune_val = (ram_rdata > 14'd1) ? prune_x7[HISTO_W+2:3] : ram_rdata;
   assign ridx_ok  = 32'(ridx_ff) < NUM_BUCKETS;

   // age test; a negative earliest start makes now - earliest exact and positive
   always_comb begin
      if (earliest_ff[63]) begin
         old_enough = age > {1'b0, rit_ff};
      end else if (earliest_ff <= now64) begin
         old_enough = age > {1'b0, rit_ff};
      end else begin
         old_enough = 1'b0;
      end
   end

   // sample offset, saturated at 2^63
   always_comb begin
      if (a_ff > 60'h800_0000_0000_0000) begin
         off = SIGN64;
      end else if (r_sum > SIGN64) begin
         off = SIGN64;
      end else begin
         off = r_sum;
      end
   end

   always_comb begin
      now_in      = now_ff;
      nsamp_in    = nsamp_ff;
      ridx_in     = ridx_ff;
      earliest_in = earliest_ff;
      latest_in   = latest_ff;
      samples_in  = samples_ff;
      restart_in  = restart_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      start_in    = start_ff;
      spread_in   = spread_ff;
      delta_in    = delta_ff;
      ge_in       = ge_ff;
      drop_in     = drop_ff;
      warn_in     = warn_ff;
      rem_in      = rem_ff;
      div_in      = div_ff;
      q_in        = q_ff;
      idx_in      = idx_ff;
      dtot_in     = dtot_ff;
      wtot_in     = wtot_ff;

      if (cmd.load) begin
         now_in   = req_data.now_ticks;
         nsamp_in = req_data.block_samples;
         ridx_in  = req_data.histo_read_index;
      end
      if (cmd.check) begin
         restart_in = (samples_ff == '0) || old_enough;
         if (restart_in) begin
            earliest_in = now64;
            latest_in   = now64;
            samples_in  = '0;
         end
      end
      if (cmd.mul_a) begin
         a_in = samples_ff * tps_ff[39:20];
      end
      if (cmd.mul_b) begin
         // full 60-bit product before dropping the 16 fraction bits
         b_in = 44'((60'(samples_ff) * 60'(tps_ff[19:0])) >> 16);
      end
      if (cmd.sum) begin
         start_in   = now64 - off;
         samples_in = samp_sum[40] ? '1 : samp_sum[39:0];
      end
      if (cmd.upd) begin
         if ($signed(start_ff) < $signed(earliest_ff)) earliest_in = start_ff;
         if ($signed(latest_ff) < $signed(start_ff))   latest_in   = start_ff;
      end
      if (cmd.meas) begin
         spread_in = latest_ff - earliest_ff;
         delta_in  = start_ff - earliest_ff;
      end
      if (cmd.scale) begin
         ge_in   = delta_ff >= {32'b0, bt_eff};
         drop_in = spread_ff > {32'b0, bt_eff};
         rem_in  = PW'(delta_ff[31:0]) * PW'(NUM_BUCKETS - 1);
         div_in  = PW'(bt_eff) << (BW - 1);
         q_in    = '0;
      end
      // restoring divide, one quotient bit a cycle
      if (cmd.div_step) begin
         if (rem_ff >= div_ff) begin
            rem_in = rem_ff - div_ff;
            q_in   = BW'({q_ff, 1'b1});
         end else begin
            q_in   = BW'({q_ff, 1'b0});
         end
         div_in = div_ff >> 1;
      end
      if (cmd.finish) begin
         warn_in = 1'b0;
         if (drop_ff) begin
            if (dtot_ff != '1) dtot_in = dtot_ff + 32'd1;
            earliest_in = '0;
            latest_in   = '0;
            samples_in  = '0;
         end else if (bucket >= HALF) begin
            warn_in = 1'b1;
            if (wtot_ff != '1) wtot_in = wtot_ff + 32'd1;
         end
      end
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   // histogram port
   assign ram_we = cmd.ram_we;
   always_comb begin
      case (cmd.wsel)
         WSEL_INC: begin
            ram_waddr = bucket;
            ram_wdata = inc_val;
         end
         WSEL_PRUNE: begin
            ram_waddr = idx_ff;
            ram_wdata = prune_val;
         end
         default: begin
            ram_waddr = idx_ff;
            ram_wdata = '0;
         end
      endcase
      case (cmd.rsel)
         RSEL_SWEEP: ram_raddr = idx_ff;
         RSEL_USER:  ram_raddr = BW'(ridx_ff);
         default:    ram_raddr = bucket;
      endcase
   end

   // result register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (cmd.out_load) begin
         rsp_valid_in             = 1'b1;
         rsp_in.dropout           = drop_ff;
         rsp_in.warning           = warn_ff;
         rsp_in.click             = (drop_ff && cod_ff) ? CLICK_POS :
                                    (warn_ff && cow_ff) ? CLICK_NEG : CLICK_NONE;
         rsp_in.bucket            = 5'(bucket);
         rsp_in.spread_ticks      = spread_ff[63] ? '1 : spread_ff[62:0];
         rsp_in.delta_ticks       = delta_ff[63] ? '1 : delta_ff[62:0];
         rsp_in.restarted         = restart_ff;
         rsp_in.dropouts_so_far   = dtot_ff;
         rsp_in.warnings_so_far   = wtot_ff;
         rsp_in.histo_read_value  = ridx_ok ? ram_rdata : '0;
      end
   end

   assign sts.idx_end    = idx_ff == TOP_BUCKET;
   assign sts.div_last   = idx_ff == BW'(BW - 1);
   assign sts.prune_need = inc_val > PRUNE_LIMIT;
   assign sts.out_free   = ~rsp_valid_ff | rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff       <= TPS_RESET;
         bt_ff        <= BLOCK_RESET;
         rit_ff       <= RESTART_RESET;
         cod_ff       <= 1'b0;
         cow_ff       <= 1'b0;
         earliest_ff  <= '0;
         latest_ff    <= '0;
         samples_ff   <= '0;
         idx_ff       <= '0;
         dtot_ff      <= '0;
         wtot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tps_ff       <= tps_in;
         bt_ff        <= bt_in;
         rit_ff       <= rit_in;
         cod_ff       <= cod_in;
         cow_ff       <= cow_in;
         earliest_ff  <= earliest_in;
         latest_ff    <= latest_in;
         samples_ff   <= samples_in;
         idx_ff       <= idx_in;
         dtot_ff      <= dtot_in;
         wtot_ff      <= wtot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      now_ff     <= now_in;
      nsamp_ff   <= nsamp_in;
      ridx_ff    <= ridx_in;
      restart_ff <= restart_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      start_ff   <= start_in;
      spread_ff  <= spread_in;
      delta_ff   <= delta_in;
      ge_ff      <= ge_in;
      drop_ff    <= drop_in;
      warn_ff    <= warn_in;
      rem_ff     <= rem_in;
      div_ff     <= div_in;
      q_ff       <= q_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.click != 2'd3)
      else $error("bad click code");
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> !(rsp_ff.dropout && rsp_ff.warning))
      else $error("dropout and warning together");
   assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && drop_ff) |=> samples_ff == '0 && earliest_ff == '0)
      else $error("tracking not cleared after dropout");

endmodule
